### sv/mfep_pkg.sv
// ----------------------------------------------------------------------------
// mfep_pkg
// Shared types and constants for the MIDI file event parser.
// ----------------------------------------------------------------------------
package mfep_pkg;

  localparam logic [1:0] KIND_EVENT  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] EV_TEMPO    = 3'd0;
  localparam logic [2:0] EV_NOTE_ON  = 3'd1;
  localparam logic [2:0] EV_NOTE_OFF = 3'd2;
  localparam logic [2:0] EV_SUSTAIN  = 3'd3;
  localparam logic [2:0] EV_ALL_OFF  = 3'd4;
  localparam logic [2:0] EV_END_TRK  = 3'd5;
  localparam logic [2:0] EV_DIVISION = 3'd6;
  localparam logic [2:0] EV_OTHER    = 3'd7;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_HDR_LEN  = 3'd1;
  localparam logic [2:0] ERR_ZERO_DIV = 3'd2;
  localparam logic [2:0] ERR_FORMAT   = 3'd3;
  localparam logic [2:0] ERR_KEY_PRES = 3'd4;
  localparam logic [2:0] ERR_TRUNC    = 3'd5;
  localparam logic [2:0] ERR_SYSTEM   = 3'd6;

  localparam logic [31:0] TAG_HEAD  = 32'h4D546864;
  localparam logic [31:0] TAG_TRACK = 32'h4D54726B;

  localparam logic [7:0] META_EOT   = 8'h2F;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TSIG  = 8'h58;
  localparam logic [7:0] META_KSIG  = 8'h59;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] delta_time;
    logic [2:0]  event_code;
    logic [7:0]  field_a;
    logic [15:0] field_b;
    logic [7:0]  field_c;
    logic [2:0]  error_code;
    logic        last_of_run;
  } out_word_t;

  // depth must be a power of two; pointers wrap naturally
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

endpackage

### sv/mfep_if.sv
// ----------------------------------------------------------------------------
// mfep_in_if / mfep_out_if
// Valid/ready channels for input bytes and result words.
// ----------------------------------------------------------------------------
interface mfep_in_if;
  logic                 valid;
  logic                 ready;
  mfep_pkg::in_word_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mfep_out_if;
  logic                 valid;
  logic                 ready;
  mfep_pkg::out_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/mfep_front.sv
// ----------------------------------------------------------------------------
// mfep_front
// Byte parser: takes one byte a cycle while room2 is high, emits up to two result words per byte.
// ----------------------------------------------------------------------------
module mfep_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfep_pkg::in_word_t  in_word,
  input  logic                room2,
  output logic [1:0]          push_n,
  output mfep_pkg::out_word_t push0,
  output mfep_pkg::out_word_t push1
);
  import mfep_pkg::*;

  localparam logic [3:0] PH_CHUNK = 4'd0, PH_SKIP_CHUNK = 4'd1, PH_HEADER = 4'd2,
    PH_DELTA = 4'd3, PH_STATUS = 4'd4, PH_SYSEX_LEN = 4'd5, PH_SKIP_EVENT = 4'd6,
    PH_META_TYPE = 4'd7, PH_META_LEN = 4'd8, PH_META_DATA = 4'd9,
    PH_CH_FIRST = 4'd10, PH_CH_SECOND = 4'd11, PH_DONE = 4'd12;

  logic [3:0]  phase, phase_next;
  logic [2:0]  cnt, cnt_next;
  logic [31:0] len, len_next, delta, delta_next, tag, tag_next;
  logic [3:0]  chan, chan_next;
  logic [2:0]  mtype, mtype_next;
  logic [7:0]  meta, meta_next;
  logic [7:0]  h0, h1, h0_next, h1_next;
  logic [15:0] fmt, fmt_next;

  logic        go;
  logic [7:0]  b;
  logic [31:0] vl_in, vl_sum;
  logic [15:0] div;
  out_word_t   r0, r1;
  logic [1:0]  n;

  assign in_ready = room2;
  assign go = in_valid & room2;
  assign b = in_word.data_byte;
  assign div = {h0, b};

  // shared variable-length step
  always_comb begin
    vl_in = (phase == PH_DELTA) ? delta : len;
    vl_sum = vl_in + {25'd0, b[6:0]};
  end

  function automatic out_word_t mk(input logic [1:0] k, input logic [31:0] dt,
                                   input logic [2:0] c, input logic [7:0] a,
                                   input logic [15:0] fb, input logic [7:0] fc,
                                   input logic [2:0] e);
    out_word_t w;
    w.result_kind = k; w.delta_time = dt; w.event_code = c; w.field_a = a;
    w.field_b = fb; w.field_c = fc; w.error_code = e; w.last_of_run = 1'b0;
    return w;
  endfunction

  always_comb begin
    phase_next = phase; cnt_next = cnt; len_next = len; delta_next = delta;
    tag_next = tag; chan_next = chan; mtype_next = mtype; meta_next = meta;
    h0_next = h0; h1_next = h1; fmt_next = fmt;
    n = 2'd0;
    r0 = mk(KIND_EVENT, 32'd0, 3'd0, 8'd0, 16'd0, 8'd0, ERR_NONE);
    r1 = r0;
    if (phase != PH_DONE) begin
      if (in_word.end_of_file) begin
        n = 2'd1; phase_next = PH_DONE;
        if ((phase == PH_CHUNK && cnt == 3'd0) || phase == PH_SKIP_CHUNK)
          r0 = mk(KIND_FINISH, 32'd0, 3'd0, 8'd0, 16'd0, 8'd0, ERR_NONE);
        else
          r0 = mk(KIND_ERROR, 32'd0, 3'd0, 8'd0, 16'd0, 8'd0, ERR_TRUNC);
      end else begin
        unique case (phase)
          PH_CHUNK: begin
            if (!cnt[2]) tag_next = {tag[23:0], b};
            else len_next = {len[23:0], b};
            cnt_next = cnt + 3'd1;
            if (cnt == 3'd7) begin
              cnt_next = 3'd0;
              if (tag == TAG_HEAD) begin
                if (len_next != 32'd6) begin
                  n = 2'd1; phase_next = PH_DONE;
                  r0 = mk(KIND_ERROR, 32'd0, 3'd0, 8'd0, 16'd0, 8'd0, ERR_HDR_LEN);
                end else phase_next = PH_HEADER;
              end else if (tag == TAG_TRACK) begin
                delta_next = 32'd0; phase_next = PH_DELTA;
              end else if (len_next != 32'd0) phase_next = PH_SKIP_CHUNK;
            end
          end
          PH_SKIP_CHUNK: begin
            len_next = len - 32'd1;
            if (len == 32'd1) begin phase_next = PH_CHUNK; cnt_next = 3'd0; end
          end
          PH_HEADER: begin
            if (cnt < 3'd2) fmt_next = {fmt[7:0], b};
            else if (cnt == 3'd4) h0_next = b;
            cnt_next = cnt + 3'd1;
            if (cnt == 3'd5) begin
              cnt_next = 3'd0;
              r0 = mk(KIND_EVENT, 32'd0, EV_DIVISION, 8'd0, div, 8'd0, ERR_NONE);
              n = 2'd1;
              if (div == 16'd0) begin
                n = 2'd2; phase_next = PH_DONE;
                r1 = mk(KIND_ERROR, 32'd0, 3'd0, 8'd0, 16'd0, 8'd0, ERR_ZERO_DIV);
              end else if (fmt > 16'd1) begin
                n = 2'd2; phase_next = PH_DONE;
                r1 = mk(KIND_ERROR, 32'd0, 3'd0, 8'd0, 16'd0, 8'd0, ERR_FORMAT);
              end else phase_next = PH_CHUNK;
            end
          end
          PH_DELTA: begin
            if (b[7]) delta_next = {vl_sum[24:0], 7'd0};
            else begin delta_next = vl_sum; phase_next = PH_STATUS; end
          end
          PH_STATUS, PH_CH_FIRST: begin
            if (phase == PH_STATUS && (b == 8'hF0 || b == 8'hF7)) begin
              len_next = 32'd0; phase_next = PH_SYSEX_LEN;
            end else if (phase == PH_STATUS && b == 8'hFF) phase_next = PH_META_TYPE;
            else if (phase == PH_STATUS && b[7]) begin
              chan_next = b[3:0]; mtype_next = b[6:4]; phase_next = PH_CH_FIRST;
            end else if (mtype == 3'd4 || mtype == 3'd5) begin
              n = 2'd1; delta_next = 32'd0; phase_next = PH_DELTA;
              r0 = mk(KIND_EVENT, delta, EV_OTHER, 8'd0, 16'd0, 8'd0, ERR_NONE);
            end else if (mtype == 3'd7) begin
              n = 2'd1; phase_next = PH_DONE;
              r0 = mk(KIND_ERROR, 32'd0, 3'd0, 8'd0, 16'd0, 8'd0, ERR_SYSTEM);
            end else begin
              h0_next = {1'b0, b[6:0]}; phase_next = PH_CH_SECOND;
            end
          end
          PH_SYSEX_LEN, PH_META_LEN: begin
            if (b[7]) len_next = {vl_sum[24:0], 7'd0};
            else begin
              len_next = vl_sum;
              if (phase == PH_META_LEN && meta == META_EOT) begin
                n = 2'd1; phase_next = PH_CHUNK; cnt_next = 3'd0;
                r0 = mk(KIND_EVENT, delta, EV_END_TRK, 8'd0, 16'd0, 8'd0, ERR_NONE);
              end else if (phase == PH_META_LEN && (meta == META_TEMPO ||
                           meta == META_TSIG || meta == META_KSIG)) begin
                cnt_next = 3'd0; phase_next = PH_META_DATA;
              end else if (vl_sum == 32'd0) begin
                n = 2'd1; delta_next = 32'd0; phase_next = PH_DELTA;
                r0 = mk(KIND_EVENT, delta, EV_OTHER, 8'd0, 16'd0, 8'd0, ERR_NONE);
              end else phase_next = PH_SKIP_EVENT;
            end
          end
          PH_SKIP_EVENT: begin
            len_next = len - 32'd1;
            if (len == 32'd1) begin
              n = 2'd1; delta_next = 32'd0; phase_next = PH_DELTA;
              r0 = mk(KIND_EVENT, delta, EV_OTHER, 8'd0, 16'd0, 8'd0, ERR_NONE);
            end
          end
          PH_META_TYPE: begin
            meta_next = b; len_next = 32'd0; phase_next = PH_META_LEN;
          end
          PH_META_DATA: begin
            // the third tempo byte goes straight into the word
            case (cnt)
              3'd0: h0_next = b;
              3'd1: h1_next = b;
              default: ;
            endcase
            cnt_next = cnt + 3'd1;
            if ((meta == META_TEMPO && cnt == 3'd2) || (meta == META_TSIG && cnt == 3'd3)
                || (meta != META_TEMPO && meta != META_TSIG && cnt == 3'd1)) begin
              cnt_next = 3'd0; n = 2'd1; delta_next = 32'd0; phase_next = PH_DELTA;
              if (meta == META_TEMPO)
                r0 = mk(KIND_EVENT, delta, EV_TEMPO, h0, {8'd0, h1}, b, ERR_NONE);
              else
                r0 = mk(KIND_EVENT, delta, EV_OTHER, 8'd0, 16'd0, 8'd0, ERR_NONE);
            end
          end
          PH_CH_SECOND: begin
            n = 2'd1; delta_next = 32'd0; phase_next = PH_DELTA;
            if (mtype == 3'd0)
              r0 = mk(KIND_EVENT, delta, EV_NOTE_OFF, {4'd0, chan}, {8'd0, h0},
                      {1'b0, b[6:0]}, ERR_NONE);
            else if (mtype == 3'd1)
              r0 = mk(KIND_EVENT, delta, EV_NOTE_ON, {4'd0, chan}, {8'd0, h0},
                      {1'b0, b[6:0]}, ERR_NONE);
            else if (mtype == 3'd2) begin
              phase_next = PH_DONE;
              r0 = mk(KIND_ERROR, 32'd0, 3'd0, 8'd0, 16'd0, 8'd0, ERR_KEY_PRES);
            end else if (mtype == 3'd3 && h0 == 8'd64)
              r0 = mk(KIND_EVENT, delta, EV_SUSTAIN, {4'd0, chan}, {8'd0, h0},
                      {1'b0, b[6:0]}, ERR_NONE);
            else if (mtype == 3'd3 && h0 == 8'd123)
              r0 = mk(KIND_EVENT, delta, EV_ALL_OFF, {4'd0, chan}, {8'd0, h0},
                      {1'b0, b[6:0]}, ERR_NONE);
            else
              r0 = mk(KIND_EVENT, delta, EV_OTHER, 8'd0, 16'd0, 8'd0, ERR_NONE);
          end
          default: phase_next = PH_DONE;
        endcase
      end
    end
    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign push_n = go ? n : 2'd0;
  assign push0 = r0;
  assign push1 = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CHUNK; cnt <= '0; len <= '0; delta <= '0; tag <= '0;
      chan <= '0; mtype <= '0; meta <= '0; h0 <= '0; h1 <= '0; fmt <= '0;
    end else if (go) begin
      phase <= phase_next; cnt <= cnt_next; len <= len_next; delta <= delta_next;
      tag <= tag_next; chan <= chan_next; mtype <= mtype_next; meta <= meta_next;
      h0 <= h0_next; h1 <= h1_next; fmt <= fmt_next;
    end
  end
endmodule

### sv/mfep_queue.sv
// ----------------------------------------------------------------------------
// mfep_queue
// Small result FIFO: up to two words in, one word out per cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
module mfep_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  mfep_pkg::out_word_t push0,
  input  mfep_pkg::out_word_t push1,
  output logic                room2,
  mfep_out_if.source          out_ch
);
  import mfep_pkg::*;

  out_word_t mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   count;
  logic           pop;

  assign pop = out_ch.valid & out_ch.ready;
  assign out_ch.valid = (count != '0);
  assign out_ch.payload = mem[rp];
  // need space for two words regardless of pop this cycle
  assign room2 = (count <= (QAW+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp] <= push0;
    if (push_n == 2'd2) mem[wp + QAW'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      wp <= wp + QAW'(push_n);
      if (pop) rp <= rp + QAW'(1);
      count <= count + (QAW+1)'(push_n) - (QAW+1)'(pop);
    end
  end
endmodule

### sv/midi_file_event_parser.sv
// ----------------------------------------------------------------------------
// midi_file_event_parser
// Standard MIDI file byte-stream parser producing event records.
// ----------------------------------------------------------------------------
// channel  | dir | word
// in_ch    | in  | data_byte, end_of_file
// out_ch   | out | result_kind .. last_of_run
// One byte a cycle; each byte yields zero to two words into a 4-deep queue.
// Input stalls only when the queue has fewer than two free slots.
// Synchronous reset returns the parser to awaiting a chunk header.
// After finish or error, further bytes are taken and dropped.
module midi_file_event_parser (
  input  logic       clk,
  input  logic       rst,
  mfep_in_if.sink    in_ch,
  mfep_out_if.source out_ch
);
  import mfep_pkg::*;

  logic       room2;
  logic [1:0] push_n;
  out_word_t  push0, push1;

  mfep_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_word(in_ch.payload), .room2(room2), .push_n(push_n),
    .push0(push0), .push1(push1)
  );

  mfep_queue u_queue (
    .clk(clk), .rst(rst), .push_n(push_n), .push0(push0), .push1(push1),
    .room2(room2), .out_ch(out_ch)
  );
endmodule
